### rtl/core/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // pipeline shape
    localparam int DIV_STAGES = 32;
    localparam int FRONT_STAGES = 2;
    localparam int MID_STAGES = 7;
    localparam int BACK_STAGES = 3;
    localparam int LATENCY = FRONT_STAGES + DIV_STAGES + MID_STAGES + DIV_STAGES + BACK_STAGES;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } reg_idx_t;

    // compensation constants
    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_P_K1    = 32'd3038;
    localparam logic [31:0] C_P_K2    = 32'hFFFF_E343;
    localparam logic [31:0] C_P_K3    = 32'd3791;
    localparam logic [31:0] C_B7_K    = 32'd50000;
    localparam logic [31:0] C_B4_OFS  = 32'd32768;
    localparam logic [31:0] C_T_RND   = 32'd8;
    localparam logic [31:0] C_RND2    = 32'd2;

    // coefficients, already widened to 32 bits; oss stays 2 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } coef_t;

    // sideband carried alongside a division
    typedef struct packed {
        logic [31:0] word;
        logic [18:0] up;
        logic        neg;
        logic        err;
    } side_t;

    function automatic logic [31:0] sx16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return $unsigned($signed(x) >>> n);
    endfunction

endpackage

`default_nettype wire

### rtl/core/bpc_udiv.sv
`default_nettype none

module bpc_udiv (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [31:0]         num,
    input  wire logic [31:0]         den,
    input  wire bpc_pkg::side_t      side_in,
    output logic                     out_valid,
    output logic [31:0]              quo,
    output bpc_pkg::side_t           side_out
);

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] nm;
        logic [31:0] dn;
        logic [31:0] q;
    } div_t;

    // one restoring step: one quotient bit
    function automatic div_t div_step(input div_t s);
        div_t        r;
        logic [32:0] trial;
        r = s;
        trial = {s.rem, s.nm[31]};
        r.nm = {s.nm[30:0], 1'b0};
        if (trial >= {1'b0, s.dn})
        begin
            r.rem = 32'(trial - {1'b0, s.dn});
            r.q = {s.q[30:0], 1'b1};
        end
        else
        begin
            r.rem = trial[31:0];
            r.q = {s.q[30:0], 1'b0};
        end
        return r;
    endfunction

    div_t                st_reg   [bpc_pkg::DIV_STAGES];
    bpc_pkg::side_t      side_reg [bpc_pkg::DIV_STAGES];
    logic [bpc_pkg::DIV_STAGES-1:0] vld_reg;
    div_t                first;

    assign first = '{rem: 32'd0, nm: num, dn: den, q: 32'd0};

    // stage datapath
    always_ff @(posedge clk)
    begin
        st_reg[0] <= div_step(first);
        side_reg[0] <= side_in;
        for (int k = 1; k < bpc_pkg::DIV_STAGES; k++)
        begin
            st_reg[k] <= div_step(st_reg[k-1]);
            side_reg[k] <= side_reg[k-1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[bpc_pkg::DIV_STAGES-2:0], in_valid};
    end

    assign out_valid = vld_reg[bpc_pkg::DIV_STAGES-1];
    assign quo = st_reg[bpc_pkg::DIV_STAGES-1].q;
    assign side_out = side_reg[bpc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/bpc_temp.sv
`default_nettype none

module bpc_temp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [15:0]     raw_temp,
    input  wire logic [18:0]     raw_press,
    input  wire bpc_pkg::coef_t  coef,
    output logic                 out_valid,
    output logic [31:0]          num,
    output logic [31:0]          den,
    output bpc_pkg::side_t       side
);

    logic           v1_reg;
    logic           v2_reg;
    logic [31:0]    m1_reg;
    logic [18:0]    up1_reg;
    logic [31:0]    num_reg;
    logic [31:0]    den_reg;
    bpc_pkg::side_t side_reg;

    logic [31:0]    x1;
    logic [31:0]    den_s;
    logic [31:0]    num_s;
    logic [31:0]    num_next;
    logic [31:0]    den_next;
    bpc_pkg::side_t side_next;

    // divisor and dividend with signs split off
    always_comb
    begin
        x1 = bpc_pkg::asr(m1_reg, 5'd15);
        den_s = x1 + coef.md;
        num_s = {coef.mc[20:0], 11'd0};
        num_next = num_s[31] ? 32'(-num_s) : num_s;
        den_next = den_s[31] ? 32'(-den_s) : den_s;
        side_next.word = x1;
        side_next.up = up1_reg;
        side_next.neg = num_s[31] ^ den_s[31];
        side_next.err = (den_s == 32'd0);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        m1_reg <= ({16'd0, raw_temp} - coef.ac6) * coef.ac5;
        up1_reg <= raw_press;
        num_reg <= num_next;
        den_reg <= den_next;
        side_reg <= side_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign num = num_reg;
    assign den = den_reg;
    assign side = side_reg;

endmodule

`default_nettype wire

### rtl/core/bpc_press.sv
`default_nettype none

module bpc_press (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [31:0]     quo,
    input  wire bpc_pkg::side_t  side_in,
    input  wire bpc_pkg::coef_t  coef,
    output logic                 out_valid,
    output logic [31:0]          num,
    output logic [31:0]          den,
    output bpc_pkg::side_t       side_out
);

    logic [bpc_pkg::MID_STAGES-1:0] vld_reg;

    logic [31:0] b5_reg;
    logic [31:0] t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic [18:0] up1_reg, up2_reg, up3_reg, up4_reg;
    logic        e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg, e7_reg;
    logic [31:0] mb6_reg, mac2_reg, mac3_reg;
    logic [31:0] mb2_reg, mb1_reg, x2a_reg, x1c_reg;
    logic [31:0] b3_reg, x3b_reg;
    logic [31:0] mb4_reg, diff_reg;
    logic [31:0] b4_reg, b7_reg;
    logic [31:0] num_reg, den_reg;
    logic        br_reg;

    logic [31:0] x2q;
    logic [31:0] b6;
    logic [31:0] sq;
    logic [31:0] x3;
    logic [31:0] b3_next;
    logic [31:0] x3b_next;
    logic [31:0] b4_next;

    always_comb
    begin
        x2q = side_in.neg ? 32'(-quo) : quo;
        b6 = b5_reg - bpc_pkg::C_B6_OFS;
        sq = bpc_pkg::asr(mb6_reg, 5'd12);
        x3 = bpc_pkg::asr(mb2_reg, 5'd11) + x2a_reg;
        b3_next = bpc_pkg::asr(32'(({coef.ac1[29:0], 2'b00} + x3) << coef.oss)
                               + bpc_pkg::C_RND2, 5'd2);
        x3b_next = bpc_pkg::asr(x1c_reg + bpc_pkg::asr(mb1_reg, 5'd16)
                                + bpc_pkg::C_RND2, 5'd2);
        b4_next = {15'd0, mb4_reg[31:15]};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        // b5 from the signed quotient
        b5_reg <= side_in.word + x2q;
        up1_reg <= side_in.up;
        e1_reg <= side_in.err;
        // b6 products and temperature
        t2_reg <= bpc_pkg::asr(b5_reg + bpc_pkg::C_T_RND, 5'd4);
        mb6_reg <= b6 * b6;
        mac2_reg <= coef.ac2 * b6;
        mac3_reg <= coef.ac3 * b6;
        up2_reg <= up1_reg;
        e2_reg <= e1_reg;
        // square term products
        mb2_reg <= coef.b2 * sq;
        mb1_reg <= coef.b1 * sq;
        x2a_reg <= bpc_pkg::asr(mac2_reg, 5'd11);
        x1c_reg <= bpc_pkg::asr(mac3_reg, 5'd13);
        t3_reg <= t2_reg;
        up3_reg <= up2_reg;
        e3_reg <= e2_reg;
        // b3 and the b4 term
        b3_reg <= b3_next;
        x3b_reg <= x3b_next;
        t4_reg <= t3_reg;
        up4_reg <= up3_reg;
        e4_reg <= e3_reg;
        // b4 product and up minus b3
        mb4_reg <= coef.ac4 * (x3b_reg + bpc_pkg::C_B4_OFS);
        diff_reg <= {13'd0, up4_reg} - b3_reg;
        t5_reg <= t4_reg;
        e5_reg <= e4_reg;
        // b7 and b4
        b4_reg <= b4_next;
        b7_reg <= diff_reg * (bpc_pkg::C_B7_K >> coef.oss);
        t6_reg <= t5_reg;
        e6_reg <= e5_reg | (b4_next == 32'd0);
        // pick the division branch
        br_reg <= b7_reg[31];
        num_reg <= b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
        den_reg <= b4_reg;
        t7_reg <= t6_reg;
        e7_reg <= e6_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[bpc_pkg::MID_STAGES-2:0], in_valid};
    end

    assign out_valid = vld_reg[bpc_pkg::MID_STAGES-1];
    assign num = num_reg;
    assign den = den_reg;
    assign side_out = '{word: t7_reg, up: 19'd0, neg: br_reg, err: e7_reg};

endmodule

`default_nettype wire

### rtl/core/bpc_post.sv
`default_nettype none

module bpc_post (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [31:0]     quo,
    input  wire bpc_pkg::side_t  side_in,
    output logic                 out_valid,
    output logic [31:0]          temp_out,
    output logic [31:0]          press_out,
    output logic                 err_out
);

    logic [bpc_pkg::BACK_STAGES-1:0] vld_reg;
    logic [31:0] p1_reg, p2_reg;
    logic [31:0] ma_reg, mb_reg;
    logic [31:0] mc_reg, x2_reg;
    logic [31:0] t1_reg, t2_reg;
    logic        e1_reg, e2_reg;
    logic [31:0] temp_reg, press_reg;
    logic        err_reg;

    logic [31:0] p;
    logic [31:0] pa;
    logic [31:0] p_fin;

    always_comb
    begin
        p = side_in.neg ? {quo[30:0], 1'b0} : quo;
        pa = bpc_pkg::asr(p, 5'd8);
        p_fin = p2_reg + bpc_pkg::asr(bpc_pkg::asr(mc_reg, 5'd16) + x2_reg
                                      + bpc_pkg::C_P_K3, 5'd4);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        // first correction products
        p1_reg <= p;
        ma_reg <= pa * pa;
        mb_reg <= bpc_pkg::C_P_K2 * p;
        t1_reg <= side_in.word;
        e1_reg <= side_in.err;
        // second correction product
        p2_reg <= p1_reg;
        mc_reg <= ma_reg * bpc_pkg::C_P_K1;
        x2_reg <= bpc_pkg::asr(mb_reg, 5'd16);
        t2_reg <= t1_reg;
        e2_reg <= e1_reg;
        // final sum, zeros on a failed division
        temp_reg <= e2_reg ? 32'd0 : t2_reg;
        press_reg <= e2_reg ? 32'd0 : p_fin;
        err_reg <= e2_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[bpc_pkg::BACK_STAGES-2:0], in_valid};
    end

    assign out_valid = vld_reg[bpc_pkg::BACK_STAGES-1];
    assign temp_out = temp_reg;
    assign press_out = press_reg;
    assign err_out = err_reg;

endmodule

`default_nettype wire

### rtl/core/barometric_pressure_compensation.sv
// throughput: one word per cycle; busy stays low and the receiver cannot stall
// the two 32-step divider pipelines (temperature and pressure) make up most of the latency
// reset: rst_n clears all valid bits and the coefficient registers to zero
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        raw_temp,
    input  wire logic [18:0]        raw_press,
    output logic                    done,
    output logic signed [31:0]      temp_tenths,
    output logic signed [31:0]      press_pa,
    output logic                    div_error
);

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    bpc_pkg::coef_t coef;

    logic           tv, dtv, pv, dpv;
    logic [31:0]    t_num, t_den, t_quo, p_num, p_den, p_quo;
    bpc_pkg::side_t t_side, dt_side, p_side, dp_side;
    logic [31:0]    temp_w, press_w;
    logic           accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg <= '0;
            mcmd_reg <= '0;
            oss_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bpc_pkg::reg_idx_t'(cfg_addr))
                bpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_wdata;
                bpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_wdata;
                bpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_wdata;
                bpc_pkg::REG_B1_B2:   b12_reg <= cfg_wdata;
                bpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_wdata;
                bpc_pkg::REG_OSS:     oss_reg <= cfg_wdata[1:0];
                default:              ;
            endcase
        end
    end

    // unpack coefficients
    always_comb
    begin
        coef.ac1 = bpc_pkg::sx16(ac12_reg[31:16]);
        coef.ac2 = bpc_pkg::sx16(ac12_reg[15:0]);
        coef.ac3 = bpc_pkg::sx16(ac34_reg[31:16]);
        coef.ac4 = {16'd0, ac34_reg[15:0]};
        coef.ac5 = {16'd0, ac56_reg[31:16]};
        coef.ac6 = {16'd0, ac56_reg[15:0]};
        coef.b1 = bpc_pkg::sx16(b12_reg[31:16]);
        coef.b2 = bpc_pkg::sx16(b12_reg[15:0]);
        coef.mc = bpc_pkg::sx16(mcmd_reg[31:16]);
        coef.md = bpc_pkg::sx16(mcmd_reg[15:0]);
        coef.oss = oss_reg;
    end

    assign busy = 1'b0;
    assign accept = start && !busy;

    bpc_temp u_temp (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .raw_temp(raw_temp), .raw_press(raw_press), .coef(coef),
        .out_valid(tv), .num(t_num), .den(t_den), .side(t_side)
    );

    bpc_udiv u_div_temp (
        .clk(clk), .rst_n(rst_n), .in_valid(tv), .num(t_num), .den(t_den),
        .side_in(t_side), .out_valid(dtv), .quo(t_quo), .side_out(dt_side)
    );

    bpc_press u_press (
        .clk(clk), .rst_n(rst_n), .in_valid(dtv), .quo(t_quo), .side_in(dt_side),
        .coef(coef), .out_valid(pv), .num(p_num), .den(p_den), .side_out(p_side)
    );

    bpc_udiv u_div_press (
        .clk(clk), .rst_n(rst_n), .in_valid(pv), .num(p_num), .den(p_den),
        .side_in(p_side), .out_valid(dpv), .quo(p_quo), .side_out(dp_side)
    );

    bpc_post u_post (
        .clk(clk), .rst_n(rst_n), .in_valid(dpv), .quo(p_quo), .side_in(dp_side),
        .out_valid(done), .temp_out(temp_w), .press_out(press_w), .err_out(div_error)
    );

    assign temp_tenths = $signed(temp_w);
    assign press_pa = $signed(press_w);

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(bpc_pkg::LATENCY) done)
        else $error("result missing after pipeline latency");

    // no result without a word accepted
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##(bpc_pkg::LATENCY) !done)
        else $error("result without accepted word");

    // a failed division reports zeros
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_error) |-> (temp_w == 32'd0 && press_w == 32'd0))
        else $error("nonzero result with division error");

endmodule

`default_nettype wire
